// File: hdl/knnpcs_pkg.sv
`default_nettype none
package knnpcs_pkg;

   localparam int DEF_MAX_POINTS  = 16;
   localparam int DEF_TOP_K       = 3;
   localparam int DEF_COORD_WIDTH = 16;

   // fixed port widths
   localparam int COORD_IN_WIDTH = 16;
   localparam int QIDX_WIDTH     = 4;
   localparam int RANK_WIDTH     = 2;
   localparam int NIDX_WIDTH     = 4;

   typedef struct packed {
      logic valid;
      logic first;
   } dist_ctl_type;

   typedef struct packed {
      logic clear;
      logic insert;
   } list_ctl_type;

endpackage
`default_nettype wire

// File: hdl/knnpcs_ram.sv
`default_nettype none
module knnpcs_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// File: hdl/knnpcs_dist.sv
`default_nettype none
module knnpcs_dist #(
   parameter int COORD_WIDTH = knnpcs_pkg::DEF_COORD_WIDTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire knnpcs_pkg::dist_ctl_type   ctl,
   input  wire logic [COORD_WIDTH-1:0]     coord_a,
   input  wire logic [COORD_WIDTH-1:0]     coord_b,
   output      logic [2*COORD_WIDTH+1:0]   sum_sq
);

   localparam int CW = COORD_WIDTH;
   localparam int SW = 2 * CW + 2;

   logic signed [CW:0]   diff;
   logic        [CW:0]   mag;
   logic        [2*CW-1:0] sq_in;
   logic        [2*CW-1:0] sq_ff;
   logic                 sq_valid_ff;
   logic                 sq_first_ff;
   logic        [SW-1:0] acc_ff;

   always_comb begin
      diff  = $signed({coord_a[CW-1], coord_a}) - $signed({coord_b[CW-1], coord_b});
      mag   = diff[CW] ? $unsigned(-diff) : $unsigned(diff);
      sq_in = mag[CW-1:0] * mag[CW-1:0];
   end

   // square one axis into a register, then fold it into the running sum in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         sq_first_ff <= 1'b0;
      end else begin
         sq_valid_ff <= ctl.valid;
         sq_first_ff <= ctl.first;
      end
      sq_ff <= sq_in;
      if (sq_valid_ff) begin
         acc_ff <= sq_first_ff ? SW'(sq_ff) : acc_ff + SW'(sq_ff);
      end
   end

   assign sum_sq = acc_ff;

endmodule
`default_nettype wire

// File: hdl/knnpcs_list.sv
`default_nettype none
module knnpcs_list #(
   parameter int TOP_K      = knnpcs_pkg::DEF_TOP_K,
   parameter int DIST_WIDTH = 2 * knnpcs_pkg::DEF_COORD_WIDTH + 2,
   parameter int IDX_WIDTH  = 4,
   parameter int RW         = (TOP_K > 1) ? $clog2(TOP_K) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire knnpcs_pkg::list_ctl_type ctl,
   input  wire logic [DIST_WIDTH-1:0]    cand_dist,
   input  wire logic [IDX_WIDTH-1:0]     cand_idx,
   input  wire logic [RW-1:0]            rank,
   output      logic [IDX_WIDTH-1:0]     rank_idx,
   output      logic                     rank_valid
);

   logic [DIST_WIDTH-1:0] dist_ff  [TOP_K];
   logic [IDX_WIDTH-1:0]  idx_ff   [TOP_K];
   logic [TOP_K-1:0]      valid_ff;
   logic [TOP_K-1:0]      closer;

   // closer is monotone over the sorted list: the first set bit is the insert slot
   always_comb begin
      for (int d = 0; d < TOP_K; d++) begin
         closer[d] = !valid_ff[d] || (cand_dist < dist_ff[d]);
      end
   end

   for (genvar d = 0; d < TOP_K; d++) begin : g_slot
      if (d == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (reset || ctl.clear) begin
               valid_ff[d] <= 1'b0;
            end else if (ctl.insert && closer[d]) begin
               valid_ff[d] <= 1'b1;
            end
            if (ctl.insert && closer[d]) begin
               dist_ff[d] <= cand_dist;
               idx_ff[d]  <= cand_idx;
            end
         end
      end else begin : g_tail
         always_ff @(posedge clock) begin
            if (reset || ctl.clear) begin
               valid_ff[d] <= 1'b0;
            end else if (ctl.insert && closer[d]) begin
               valid_ff[d] <= closer[d-1] ? valid_ff[d-1] : 1'b1;
            end
            if (ctl.insert && closer[d]) begin
               // shift down from above, or take the candidate at the slot
               dist_ff[d] <= closer[d-1] ? dist_ff[d-1] : cand_dist;
               idx_ff[d]  <= closer[d-1] ? idx_ff[d-1]  : cand_idx;
            end
         end
      end
   end

   assign rank_idx   = idx_ff[rank];
   assign rank_valid = valid_ff[rank];

endmodule
`default_nettype wire

// File: hdl/knn_point_cloud_selector.sv
`default_nettype none
// k-nearest-neighbor selector for a small 3-D point cloud.
// Input: one point per transaction on req_coord_x/y/z, taken when start is high
// and busy is low. Points fill the store in order; those beyond MAX_POINTS are
// dropped. A point without req_last_point leaves busy low.
// A transaction with req_last_point raises busy and runs the search: for each
// stored point (query) every other point goes through one shared
// subtract/square/accumulate unit, one axis per cycle, then into a sorted
// insertion list of TOP_K entries.
// Each candidate step: store read, three axis passes, accumulate, insert.
// Output: TOP_K results per query, query ascending, nearest first, each on the
// rsp_ ports for one cycle under rsp_valid; rsp_last marks the final one, and
// busy falls in that same cycle. The receiver cannot stall, so results are
// never held. Unfilled ranks show rsp_neighbour_valid low and index zero.
// Reset clears the point count and the sequencer; the store is not cleared.
module knn_point_cloud_selector #(
   parameter int MAX_POINTS  = knnpcs_pkg::DEF_MAX_POINTS,
   parameter int TOP_K       = knnpcs_pkg::DEF_TOP_K,
   parameter int COORD_WIDTH = knnpcs_pkg::DEF_COORD_WIDTH
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output      logic                                   busy,
   input  wire logic signed [knnpcs_pkg::COORD_IN_WIDTH-1:0] req_coord_x,
   input  wire logic signed [knnpcs_pkg::COORD_IN_WIDTH-1:0] req_coord_y,
   input  wire logic signed [knnpcs_pkg::COORD_IN_WIDTH-1:0] req_coord_z,
   input  wire logic                                   req_last_point,
   output      logic                                   rsp_valid,
   output      logic [knnpcs_pkg::QIDX_WIDTH-1:0]      rsp_query_index,
   output      logic [knnpcs_pkg::RANK_WIDTH-1:0]      rsp_rank,
   output      logic [knnpcs_pkg::NIDX_WIDTH-1:0]      rsp_neighbour_index,
   output      logic                                   rsp_neighbour_valid,
   output      logic                                   rsp_last
);

   localparam int CW   = COORD_WIDTH;
   localparam int EW   = (CW > knnpcs_pkg::COORD_IN_WIDTH) ? CW : knnpcs_pkg::COORD_IN_WIDTH;
   localparam int PW   = 3 * CW;
   localparam int SW   = 2 * CW + 2;
   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CNTW = $clog2(MAX_POINTS + 1);
   localparam int RW   = (TOP_K > 1) ? $clog2(TOP_K) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_QREAD,
      S_QLATCH,
      S_CREAD,
      S_DIST,
      S_SETTLE,
      S_INSERT,
      S_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [CNTW-1:0]   count_ff, count_in;
   logic [CNTW-1:0]   q_ff, q_in;
   logic [CNTW-1:0]   c_ff, c_in;
   logic [1:0]        axis_ff, axis_in;
   logic [RW-1:0]     rank_ff, rank_in;
   logic [PW-1:0]     query_ff, query_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [knnpcs_pkg::QIDX_WIDTH-1:0] rsp_qidx_ff, rsp_qidx_in;
   logic [knnpcs_pkg::RANK_WIDTH-1:0] rsp_rank_ff, rsp_rank_in;
   logic [knnpcs_pkg::NIDX_WIDTH-1:0] rsp_nidx_ff, rsp_nidx_in;
   logic              rsp_nvalid_ff, rsp_nvalid_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [EW-1:0]     ext_x, ext_y, ext_z;
   logic              accept;
   logic              wr_en;
   logic [PW-1:0]     wr_data;
   logic [AW-1:0]     rd_addr;
   logic [PW-1:0]     rd_data;
   logic [CW-1:0]     coord_q, coord_c;
   logic [SW-1:0]     sum_sq;
   logic [AW-1:0]     rank_idx;
   logic              rank_valid;
   knnpcs_pkg::dist_ctl_type dist_ctl;
   knnpcs_pkg::list_ctl_type list_ctl;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // bits above COORD_WIDTH are ignored; a wider store sees the field unsigned
   assign ext_x   = EW'($unsigned(req_coord_x));
   assign ext_y   = EW'($unsigned(req_coord_y));
   assign ext_z   = EW'($unsigned(req_coord_z));
   assign wr_data = {ext_x[CW-1:0], ext_y[CW-1:0], ext_z[CW-1:0]};
   assign wr_en   = accept && (count_ff < CNTW'(MAX_POINTS));
   assign rd_addr = (state_ff == S_QREAD) ? q_ff[AW-1:0] : c_ff[AW-1:0];

   knnpcs_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      case (axis_ff)
         2'd0: begin
            coord_q = query_ff[3*CW-1:2*CW];
            coord_c = rd_data[3*CW-1:2*CW];
         end
         2'd1: begin
            coord_q = query_ff[2*CW-1:CW];
            coord_c = rd_data[2*CW-1:CW];
         end
         default: begin
            coord_q = query_ff[CW-1:0];
            coord_c = rd_data[CW-1:0];
         end
      endcase
   end

   assign dist_ctl.valid = (state_ff == S_DIST);
   assign dist_ctl.first = (axis_ff == 2'd0);

   knnpcs_dist #(
      .COORD_WIDTH (CW)
   ) u_dist (
      .clock   (clock),
      .reset   (reset),
      .ctl     (dist_ctl),
      .coord_a (coord_q),
      .coord_b (coord_c),
      .sum_sq  (sum_sq)
   );

   assign list_ctl.clear  = (state_ff == S_QLATCH);
   assign list_ctl.insert = (state_ff == S_INSERT);

   knnpcs_list #(
      .TOP_K      (TOP_K),
      .DIST_WIDTH (SW),
      .IDX_WIDTH  (AW),
      .RW         (RW)
   ) u_list (
      .clock      (clock),
      .reset      (reset),
      .ctl        (list_ctl),
      .cand_dist  (sum_sq),
      .cand_idx   (c_ff[AW-1:0]),
      .rank       (rank_ff),
      .rank_idx   (rank_idx),
      .rank_valid (rank_valid)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      q_in          = q_ff;
      c_in          = c_ff;
      axis_in       = axis_ff;
      rank_in       = rank_ff;
      query_in      = query_ff;
      rsp_valid_in  = 1'b0;
      rsp_qidx_in   = rsp_qidx_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_nidx_in   = rsp_nidx_ff;
      rsp_nvalid_in = rsp_nvalid_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (wr_en) begin
                  count_in = count_ff + 1'b1;
               end
               if (req_last_point) begin
                  q_in     = '0;
                  state_in = S_QREAD;
               end
            end
         end
         S_QREAD: begin
            state_in = S_QLATCH;
         end
         S_QLATCH: begin
            query_in = rd_data;
            c_in     = '0;
            state_in = S_CREAD;
         end
         S_CREAD: begin
            if (c_ff == count_ff) begin
               rank_in  = '0;
               state_in = S_EMIT;
            end else if (c_ff == q_ff) begin
               c_in = c_ff + 1'b1;
            end else begin
               axis_in  = 2'd0;
               state_in = S_DIST;
            end
         end
         S_DIST: begin
            axis_in = axis_ff + 2'd1;
            if (axis_ff == 2'd2) begin
               state_in = S_SETTLE;
            end
         end
         S_SETTLE: begin
            state_in = S_INSERT;
         end
         S_INSERT: begin
            c_in     = c_ff + 1'b1;
            state_in = S_CREAD;
         end
         S_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_qidx_in   = knnpcs_pkg::QIDX_WIDTH'(q_ff);
            rsp_rank_in   = knnpcs_pkg::RANK_WIDTH'(rank_ff);
            rsp_nidx_in   = rank_valid ? knnpcs_pkg::NIDX_WIDTH'(rank_idx) : '0;
            rsp_nvalid_in = rank_valid;
            rsp_last_in   = (q_ff == count_ff - 1'b1) && (rank_ff == RW'(TOP_K - 1));
            rank_in       = rank_ff + 1'b1;
            if (rank_ff == RW'(TOP_K - 1)) begin
               q_in = q_ff + 1'b1;
               if (q_ff == count_ff - 1'b1) begin
                  count_in = '0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_QREAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         q_ff         <= '0;
         c_ff         <= '0;
         axis_ff      <= '0;
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         q_ff         <= q_in;
         c_ff         <= c_in;
         axis_ff      <= axis_in;
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      query_ff      <= query_in;
      rsp_qidx_ff   <= rsp_qidx_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_nidx_ff   <= rsp_nidx_in;
      rsp_nvalid_ff <= rsp_nvalid_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_query_index     = rsp_qidx_ff;
   assign rsp_rank            = rsp_rank_ff;
   assign rsp_neighbour_index = rsp_nidx_ff;
   assign rsp_neighbour_valid = rsp_nvalid_ff;
   assign rsp_last            = rsp_last_ff;

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_EMIT))
      else $error("result strobe outside the emit step");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (state_ff == S_IDLE && count_ff == '0))
      else $error("final result without return to idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_POINTS))
      else $error("point count beyond store depth");

   a_load_counts: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_last_point && count_ff < CNTW'(MAX_POINTS))
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("stored point not counted");

   a_insert_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INSERT) |-> (c_ff < count_ff && c_ff != q_ff))
      else $error("candidate index out of range or equal to query");

endmodule
`default_nettype wire
